@@ design/vas_pkg.sv @@
// Shared types and constants for the valve actuation supervisor.
package vas_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_START    = 2'd1,
        FUNC_EVALUATE = 2'd2,
        FUNC_UNUSED   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STEP_IDLE   = 2'd0,
        STEP_DRIVE  = 2'd1,
        STEP_WAIT   = 2'd2,
        STEP_SETTLE = 2'd3
    } t_step;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TWO_DRIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_SWITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TMO_ENERGIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TMO_RELEASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SET_ENERGIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SET_RELEASE  = 3'd5;

    localparam logic [15:0] TIMER_RESET = 16'd2;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // Fault flag bit positions.
    localparam int unsigned FLT_ENERGIZE = 0;
    localparam int unsigned FLT_RELEASE  = 1;
    localparam int unsigned FLT_NEITHER  = 2;
    localparam int unsigned FLT_BOTH     = 3;

    typedef struct packed {
        logic [3:0] faults;
        logic       done_direction;
        logic       done_res;
        logic       busy_res;
        logic       drive_aux;
        logic       drive_main;
    } t_result;

endpackage

@@ design/valve_actuation_supervisor_top.sv @@
// Valve actuation supervisor: state update, result register and APB register file.
// Each result is registered in the output register, or in the skid register while the output one waits.
// Throughput: one transaction per cycle while the skid register is empty; state updates are combinational.
// A result register plus one skid register let input accept while a result waits.
// Reset (synchronous, active low) clears sequence state, faults and output valids
// and loads register defaults (single drive, single switch, all times 2).
module valve_actuation_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [0] action, [1] switch_primary, [2] switch_secondary
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] func
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [0] drive_main, [1] drive_aux, [2] busy_res,
                                         // [3] done_res, [4] done_direction,
                                         // [5] fault_energize, [6] fault_release,
                                         // [7] fault_neither, [8] fault_both
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic        r_two_drive;
    logic        r_two_switch;
    logic [15:0] r_tmo_energize;
    logic [15:0] r_tmo_release;
    logic [15:0] r_set_energize;
    logic [15:0] r_set_release;

    logic                            cfg_wr;
    logic [vas_pkg::CFG_IDX_W-1:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_drive    <= 1'b0;
            r_two_switch   <= 1'b0;
            r_tmo_energize <= vas_pkg::TIMER_RESET;
            r_tmo_release  <= vas_pkg::TIMER_RESET;
            r_set_energize <= vas_pkg::TIMER_RESET;
            r_set_release  <= vas_pkg::TIMER_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                vas_pkg::REG_TWO_DRIVE:    r_two_drive    <= pwdata[0];
                vas_pkg::REG_TWO_SWITCH:   r_two_switch   <= pwdata[0];
                vas_pkg::REG_TMO_ENERGIZE: r_tmo_energize <= pwdata[15:0];
                vas_pkg::REG_TMO_RELEASE:  r_tmo_release  <= pwdata[15:0];
                vas_pkg::REG_SET_ENERGIZE: r_set_energize <= pwdata[15:0];
                vas_pkg::REG_SET_RELEASE:  r_set_release  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            vas_pkg::REG_TWO_DRIVE:    prdata = {31'd0, r_two_drive};
            vas_pkg::REG_TWO_SWITCH:   prdata = {31'd0, r_two_switch};
            vas_pkg::REG_TMO_ENERGIZE: prdata = {16'd0, r_tmo_energize};
            vas_pkg::REG_TMO_RELEASE:  prdata = {16'd0, r_tmo_release};
            vas_pkg::REG_SET_ENERGIZE: prdata = {16'd0, r_set_energize};
            vas_pkg::REG_SET_RELEASE:  prdata = {16'd0, r_set_release};
            default:                   prdata = 32'd0;
        endcase
    end

    // sequence state
    vas_pkg::t_step r_step;
    logic [15:0]    r_elapsed;
    logic           r_drive_main;
    logic           r_drive_aux;
    logic [3:0]     r_faults;

    vas_pkg::t_step n_step;
    logic [15:0]    n_elapsed;
    logic           n_drive_main;
    logic           n_drive_aux;
    logic [3:0]     n_faults;
    logic           n_done;

    vas_pkg::t_func in_func;
    logic           in_act;
    logic           in_sp;
    logic           in_ss;
    logic [15:0]    tmo;
    logic [15:0]    settle;
    logic [3:0]     dir_flag;
    logic           agree;

    assign in_func  = vas_pkg::t_func'(i_s_axis_tuser);
    assign in_act   = i_s_axis_tdata[0];
    assign in_sp    = i_s_axis_tdata[1];
    assign in_ss    = i_s_axis_tdata[2];
    assign tmo      = in_act ? r_tmo_energize : r_tmo_release;
    assign settle   = in_act ? r_set_energize : r_set_release;
    assign dir_flag = in_act ? 4'b0001 << vas_pkg::FLT_ENERGIZE
                             : 4'b0001 << vas_pkg::FLT_RELEASE;
    assign agree    = (in_sp == in_act) && (!r_two_switch || (in_ss != in_act));

    always_comb begin
        n_step       = r_step;
        n_elapsed    = r_elapsed;
        n_drive_main = r_drive_main;
        n_drive_aux  = r_drive_aux;
        n_faults     = r_faults;
        n_done       = 1'b0;
        unique case (in_func)
            vas_pkg::FUNC_TICK: begin
                if (r_elapsed != vas_pkg::ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            vas_pkg::FUNC_START: begin
                n_step = vas_pkg::STEP_DRIVE;
            end
            vas_pkg::FUNC_EVALUATE: begin
                unique case (r_step)
                    vas_pkg::STEP_DRIVE: begin
                        n_drive_main = in_act;
                        n_drive_aux  = r_two_drive & ~in_act;
                        if (agree) begin
                            n_done = 1'b1;
                            n_step = vas_pkg::STEP_IDLE;
                        end else begin
                            n_elapsed = 16'd0;
                            n_step    = vas_pkg::STEP_WAIT;
                        end
                    end
                    vas_pkg::STEP_WAIT: begin
                        if (r_two_switch) begin
                            n_faults = n_faults & ~(dir_flag
                                       | (4'b0001 << vas_pkg::FLT_NEITHER)
                                       | (4'b0001 << vas_pkg::FLT_BOTH));
                        end
                        if (agree) begin
                            if (!r_two_switch) begin
                                n_faults = n_faults & ~dir_flag;
                            end
                            n_elapsed = 16'd0;
                            n_step    = vas_pkg::STEP_SETTLE;
                        end else if (r_elapsed > tmo) begin
                            if (r_two_switch && !in_sp && !in_ss) begin
                                n_faults[vas_pkg::FLT_NEITHER] = 1'b1;
                            end else if (r_two_switch && in_sp && in_ss) begin
                                n_faults[vas_pkg::FLT_BOTH] = 1'b1;
                            end else begin
                                n_faults = n_faults | dir_flag;
                            end
                        end
                    end
                    vas_pkg::STEP_SETTLE: begin
                        if (r_elapsed >= settle) begin
                            n_done = 1'b1;
                            n_step = vas_pkg::STEP_IDLE;
                        end
                    end
                    vas_pkg::STEP_IDLE: ;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    vas_pkg::t_result n_result;

    always_comb begin
        n_result.drive_main     = n_drive_main;
        n_result.drive_aux      = n_drive_aux;
        n_result.busy_res       = (n_step != vas_pkg::STEP_IDLE);
        n_result.done_res       = n_done;
        n_result.done_direction = n_done & in_act;
        n_result.faults         = n_faults;
    end

    // output register with skid
    logic             r_out_valid;
    vas_pkg::t_result r_out;
    logic             r_skid_valid;
    vas_pkg::t_result r_skid;
    logic             push;
    logic             pop;

    assign o_s_axis_tready = ~r_skid_valid;
    assign push            = i_s_axis_tvalid & o_s_axis_tready;
    assign pop             = r_out_valid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= vas_pkg::STEP_IDLE;
            r_elapsed    <= 16'd0;
            r_drive_main <= 1'b0;
            r_drive_aux  <= 1'b0;
            r_faults     <= 4'd0;
        end else if (push) begin
            r_step       <= n_step;
            r_elapsed    <= n_elapsed;
            r_drive_main <= n_drive_main;
            r_drive_aux  <= n_drive_aux;
            r_faults     <= n_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out};

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output register is empty");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while sequence still busy");

    a_dir_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_direction) |-> r_out.done_res)
        else $error("done direction set without done");

    a_elapsed_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elapsed != $past(r_elapsed)) |->
            (r_elapsed == 16'd0 || r_elapsed == $past(r_elapsed) + 16'd1))
        else $error("elapsed counter jumped");

endmodule
